[rtl/lpki_pkg.sv]
package lpki_pkg;

   // field widths
   localparam int KEY_W    = 64;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;
   localparam int COUNT_W  = 11;
   localparam int CAP_W    = 4;

   // reserved keys
   localparam logic [KEY_W-1:0] KEY_EMPTY = 64'd0;
   localparam logic [KEY_W-1:0] KEY_TOMB  = 64'd1;

   // capacity register reset value
   localparam logic [CAP_W-1:0] CAP_LOG2_RESET = 4'd10;

   // operation codes (code 3 behaves as a lookup)
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                was_present;
      logic [COUNT_W-1:0]  live_count;
   } rsp_type;

endpackage

[rtl/linear_probe_key_index_top.sv]
// channel  | direction | handshake               | payload
// req      | in        | req_valid / req_ready   | req_data (kind, key)
// rsp      | out       | rsp_valid / rsp_ready   | rsp_data (status, slot, was_present, live_count)
// csr      | in        | csr_write_en            | csr_write_data (capacity_log2)
//
// an operation probes k slots before the next accept, k running from 1 up to the active
// capacity, with one memory read per probed slot
// a reserved key is answered with no probe
// after reset the key memory is cleared one entry a cycle, all SLOTS entries, with req_ready low
// the next request is taken while a result waits in the output register; a stalled result
// holds the following one in the finish state until the output register frees up
module linear_probe_key_index_top #(
   parameter int SLOTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lpki_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lpki_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_en,
   input  logic [lpki_pkg::CAP_W-1:0]   csr_write_data
);

   localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CAP_LOG2_MAX = $clog2(SLOTS + 1) - 1;
   localparam logic [4:0] LG_MAX   = 5'(CAP_LOG2_MAX);
   localparam logic [IDX_W-1:0] CLR_END = IDX_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [lpki_pkg::CAP_W-1:0]      cap_log2_ff, cap_log2_in;
   logic [IDX_W-1:0]                clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]                cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]                step_ff, step_in;
   logic [IDX_W-1:0]                tomb_idx_ff, tomb_idx_in;
   logic                            tomb_vld_ff, tomb_vld_in;
   logic [lpki_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [lpki_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [lpki_pkg::COUNT_W-1:0]    live_ff, live_in;
   lpki_pkg::rsp_type               res_ff, res_in;
   lpki_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [lpki_pkg::KEY_W-1:0]      mem [SLOTS];
   logic [lpki_pkg::KEY_W-1:0]      rd_data_ff;
   logic [IDX_W-1:0]                rd_addr;
   logic                            wr_en;
   logic [IDX_W-1:0]                wr_addr;
   logic [lpki_pkg::KEY_W-1:0]      wr_data;

   logic [4:0]                      lg_eff;
   logic [IDX_W-1:0]                mask;
   logic                            req_beat;
   logic                            out_free;
   logic                            hit, empty, tomb, last;

   // active capacity mask
   always_comb begin
      lg_eff = (cap_log2_ff == '0) ? 5'd1 : {1'b0, cap_log2_ff};
      if (lg_eff > LG_MAX) begin
         lg_eff = LG_MAX;
      end
      for (int i = 0; i < IDX_W; i++) begin
         mask[i] = (5'(i) < lg_eff);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // probe slot classification
   assign hit   = (rd_data_ff == key_ff);
   assign empty = (rd_data_ff == lpki_pkg::KEY_EMPTY);
   assign tomb  = (rd_data_ff == lpki_pkg::KEY_TOMB);
   assign last  = (step_ff == mask);

   // next state and memory control
   always_comb begin
      state_in     = state_ff;
      cap_log2_in  = csr_write_en ? csr_write_data : cap_log2_ff;
      clr_idx_in   = clr_idx_ff;
      cur_idx_in   = cur_idx_ff;
      step_in      = step_ff;
      tomb_idx_in  = tomb_idx_ff;
      tomb_vld_in  = tomb_vld_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      live_in      = live_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = (cur_idx_ff + IDX_W'(1)) & mask;
      wr_en        = 1'b0;
      wr_addr      = cur_idx_ff;
      wr_data      = key_ff;

      case (state_ff)
         // sweep the key memory to empty
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = lpki_pkg::KEY_EMPTY;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == CLR_END) begin
               state_in = S_IDLE;
            end
         end

         // take a request and issue the home slot read
         S_IDLE: begin
            rd_addr = IDX_W'(req_data.key) & mask;
            if (req_beat) begin
               kind_in     = req_data.kind;
               key_in      = req_data.key;
               cur_idx_in  = IDX_W'(req_data.key) & mask;
               step_in     = '0;
               tomb_vld_in = 1'b0;
               if (req_data.key == lpki_pkg::KEY_EMPTY || req_data.key == lpki_pkg::KEY_TOMB) begin
                  res_in   = '{lpki_pkg::STATUS_INVALID, '0, 1'b0, live_ff};
                  state_in = S_FINISH;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end

         // check one slot a cycle while the next read is in flight
         S_PROBE: begin
            cur_idx_in = rd_addr;
            step_in    = step_ff + IDX_W'(1);
            if (tomb && !tomb_vld_ff) begin
               tomb_vld_in = 1'b1;
               tomb_idx_in = cur_idx_ff;
            end
            if (hit) begin
               state_in = S_FINISH;
               res_in   = '{lpki_pkg::STATUS_OK, lpki_pkg::SLOT_W'(cur_idx_ff), 1'b1, live_ff};
               if (kind_ff == lpki_pkg::KIND_DELETE) begin
                  wr_en   = 1'b1;
                  wr_data = lpki_pkg::KEY_TOMB;
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
                  res_in.live_count = live_in;
               end
            end else if (empty || last) begin
               state_in = S_FINISH;
               if (kind_ff == lpki_pkg::KIND_INSERT) begin
                  // claim the first tombstone passed, else the empty slot
                  if (tomb_vld_ff) begin
                     wr_addr = tomb_idx_ff;
                  end else begin
                     wr_addr = cur_idx_ff;
                  end
                  if (tomb_vld_ff || tomb || empty) begin
                     wr_en = 1'b1;
                     if (live_ff != '1) begin
                        live_in = live_ff + 1'b1;
                     end
                     res_in = '{lpki_pkg::STATUS_OK, lpki_pkg::SLOT_W'(wr_addr), 1'b0, live_in};
                  end else begin
                     res_in = '{lpki_pkg::STATUS_FULL, '0, 1'b0, live_ff};
                  end
               end else begin
                  res_in = '{lpki_pkg::STATUS_NOT_FOUND, '0, 1'b0, live_ff};
               end
            end
         end

         // hand the result to the output register
         S_FINISH: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cap_log2_ff  <= lpki_pkg::CAP_LOG2_RESET;
         clr_idx_ff   <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tomb_vld_ff  <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cap_log2_ff  <= cap_log2_in;
         clr_idx_ff   <= clr_idx_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         tomb_vld_ff  <= tomb_vld_in;
         step_ff      <= step_in;
      end
      cur_idx_ff  <= cur_idx_in;
      tomb_idx_ff <= tomb_idx_in;
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // key memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // checks
   a_count_only_in_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PROBE) |=> $stable(live_ff))
      else $error("live count changed outside a probe");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != lpki_pkg::STATUS_OK) |->
      (rsp_data_ff.slot == '0 && !rsp_data_ff.was_present))
      else $error("failed result carries a slot");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (step_ff <= mask))
      else $error("probe ran past the active capacity");

   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("memory write outside clear or probe");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !out_free) |=> (state_ff == S_FINISH && $stable(res_ff)))
      else $error("pending result lost while output stalled");

endmodule
